>>> design/shid_pkg.sv
// shared types and constants for the spead header item decoder
`timescale 1ns / 1ps
package shid_pkg;

	// widest heap address field accepted, in bits
	localparam int unsigned ADDR_FIELD_BITS = 56;

	localparam logic [7:0] SPEAD_MAGIC   = 8'h53;
	localparam logic [7:0] SPEAD_VERSION = 8'h04;

	// item identifiers handled
	localparam logic [15:0] ID_HEAP_CNT     = 16'h0001;
	localparam logic [15:0] ID_HEAP_SIZE    = 16'h0002;
	localparam logic [15:0] ID_HEAP_OFFSET  = 16'h0003;
	localparam logic [15:0] ID_PAYLOAD_LEN  = 16'h0004;
	localparam logic [15:0] ID_STREAM_CTRL  = 16'h0006;
	localparam logic [15:0] ID_TS_COUNT     = 16'h6000;
	localparam logic [15:0] ID_TS_FRACTION  = 16'h6001;
	localparam logic [15:0] ID_BASELINES    = 16'h6005;
	localparam logic [15:0] ID_SCAN_HDR     = 16'h6008;
	localparam logic [15:0] ID_VIS_OFFSET   = 16'h600A;

	localparam logic [55:0] STREAM_STOP = 56'd2;

	typedef enum logic [3:0] {
		KIND_NONE,
		KIND_HEAP_CNT,
		KIND_HEAP_SIZE,
		KIND_HEAP_OFFSET,
		KIND_PAYLOAD_LEN,
		KIND_STREAM_CTRL,
		KIND_TS_COUNT,
		KIND_TS_FRACTION,
		KIND_BASELINES,
		KIND_SCAN_HDR,
		KIND_VIS_OFFSET
	} item_kind_t;

	typedef struct packed {
		item_kind_t  kind;
		logic [55:0] addr;
	} item_fields_t;

	typedef struct packed {
		logic [63:0] word;
		logic        start_of_packet;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] heap_index;
		logic [55:0]        heap_len;
		logic [55:0]        heap_pos;
		logic [55:0]        vis_start;
		logic [55:0]        vis_length;
		logic [55:0]        vis_base_offset;
		logic [31:0]        ts_whole;
		logic [31:0]        ts_part;
		logic signed [31:0] baseline_count;
		logic               has_header_data;
		logic               stream_done;
		logic               copy_request;
	} out_beat_t;

	function automatic logic [31:0] swap32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

endpackage

>>> design/shid_item_split.sv
// splits an item pointer into its id class and address
`timescale 1ns / 1ps
module shid_item_split import shid_pkg::*; (
	input  logic [63:0]  item,
	input  logic [2:0]   addr_bytes,
	input  logic [2:0]   id_bytes,
	output item_fields_t fields
);

	logic [63:0] byte_mask;
	logic [63:0] shifted;
	logic [63:0] id_mask;
	logic [63:0] id_val;
	logic [63:0] addr_full;

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			byte_mask[k*8 +: 8] = (3'(k) < addr_bytes) ? 8'hFF : 8'h00;
		end
		addr_full = item & byte_mask;
		shifted   = item >> {addr_bytes, 3'b000};
		// id width excludes the immediate flag
		id_mask   = ((64'd1 << {id_bytes, 3'b000}) - 64'd1) >> 1;
		id_val    = shifted & id_mask;
	end

	always_comb begin
		fields.addr = addr_full[55:0];
		fields.kind = KIND_NONE;
		if (id_val[63:16] == 48'd0) begin
			case (id_val[15:0])
				ID_HEAP_CNT:    fields.kind = KIND_HEAP_CNT;
				ID_HEAP_SIZE:   fields.kind = KIND_HEAP_SIZE;
				ID_HEAP_OFFSET: fields.kind = KIND_HEAP_OFFSET;
				ID_PAYLOAD_LEN: fields.kind = KIND_PAYLOAD_LEN;
				ID_STREAM_CTRL: fields.kind = KIND_STREAM_CTRL;
				ID_TS_COUNT:    fields.kind = KIND_TS_COUNT;
				ID_TS_FRACTION: fields.kind = KIND_TS_FRACTION;
				ID_BASELINES:   fields.kind = KIND_BASELINES;
				ID_SCAN_HDR:    fields.kind = KIND_SCAN_HDR;
				ID_VIS_OFFSET:  fields.kind = KIND_VIS_OFFSET;
				default:        fields.kind = KIND_NONE;
			endcase
		end
	end

endmodule

>>> design/spead_header_item_decode_core.sv
// top level of the spead packet header and item pointer decoder
//
// channel  | direction | handshake                  | beat
// ---------+-----------+----------------------------+------------------------------
// item     | in        | item_valid / item_ready    | one 64-bit packet word + sop
// result   | out       | result_valid / result_ready| one heap descriptor
//
// one beat per cycle sustained while the result side keeps up; a word accepted
// sits in the input stage and its descriptor, if any, is loaded into the result
// register when the input stage advances, which a full result register can hold off;
// the input stage advances only when the result register is empty or being taken;
// a descriptor left waiting with the input stage full drops item_ready, whether or
// not the held word would produce a descriptor
// arst_n clears the stage valid flags and all decoder state; decoder values start at zero
`timescale 1ns / 1ps
module spead_header_item_decode_core import shid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_beat_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_beat_t result
);

	// input stage
	logic        valid_s1;
	in_beat_t    beat_s1;
	logic        advance;

	// decoder state
	logic        active_q;
	logic [2:0]  addr_bytes_q;
	logic [2:0]  id_bytes_q;
	logic [7:0]  items_left_q;
	logic [31:0] heap_cnt_q;
	logic [55:0] vis_off_q;
	logic [31:0] baselines_q;
	logic        done_q;
	logic [55:0] heap_size_q;
	logic [55:0] heap_offset_q;
	logic [55:0] payload_len_q;
	logic [55:0] vis_start_q;
	logic [31:0] ts_count_q;
	logic [31:0] ts_frac_q;
	logic        hdr_flag_q;
	logic        ctrl_flag_q;

	// next values
	logic        active_n;
	logic [2:0]  addr_bytes_n;
	logic [2:0]  id_bytes_n;
	logic [7:0]  items_left_n;
	logic [31:0] heap_cnt_n;
	logic [55:0] vis_off_n;
	logic [31:0] baselines_n;
	logic        done_n;
	logic [55:0] heap_size_n;
	logic [55:0] heap_offset_n;
	logic [55:0] payload_len_n;
	logic [55:0] vis_start_n;
	logic [31:0] ts_count_n;
	logic [31:0] ts_frac_n;
	logic        hdr_flag_n;
	logic        ctrl_flag_n;
	logic        emit;

	// result register
	logic        result_valid_q;
	out_beat_t   result_q;
	out_beat_t   result_d;

	// header fields
	logic [7:0]  hdr_magic;
	logic [7:0]  hdr_version;
	logic [7:0]  hdr_id_bytes;
	logic [7:0]  hdr_addr_bytes;
	logic [7:0]  hdr_items;
	logic        hdr_ok;
	logic [8:0]  width_sum;
	logic [10:0] addr_width_bits;

	item_fields_t fields;

	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			beat_s1 <= item;
		end
	end

	shid_item_split u_split (
		.item       (beat_s1.word),
		.addr_bytes (addr_bytes_q),
		.id_bytes   (id_bytes_q),
		.fields     (fields)
	);

	// header checks: magic, version, non-zero widths, at most 8 bytes together, address field within ADDR_FIELD_BITS
	always_comb begin
		hdr_magic       = beat_s1.word[63:56];
		hdr_version     = beat_s1.word[55:48];
		hdr_id_bytes    = beat_s1.word[47:40];
		hdr_addr_bytes  = beat_s1.word[39:32];
		hdr_items       = beat_s1.word[7:0];
		width_sum       = {1'b0, hdr_id_bytes} + {1'b0, hdr_addr_bytes};
		addr_width_bits = {hdr_addr_bytes, 3'b000};
		hdr_ok = (hdr_magic == SPEAD_MAGIC) && (hdr_version == SPEAD_VERSION) &&
			(hdr_id_bytes != 8'd0) && (hdr_addr_bytes != 8'd0) &&
			(width_sum <= 9'd8) && (addr_width_bits <= 11'(ADDR_FIELD_BITS));
	end

	// state update for the word in the input stage
	always_comb begin
		active_n      = active_q;
		addr_bytes_n  = addr_bytes_q;
		id_bytes_n    = id_bytes_q;
		items_left_n  = items_left_q;
		heap_cnt_n    = heap_cnt_q;
		vis_off_n     = vis_off_q;
		baselines_n   = baselines_q;
		done_n        = done_q;
		heap_size_n   = heap_size_q;
		heap_offset_n = heap_offset_q;
		payload_len_n = payload_len_q;
		vis_start_n   = vis_start_q;
		ts_count_n    = ts_count_q;
		ts_frac_n     = ts_frac_q;
		hdr_flag_n    = hdr_flag_q;
		ctrl_flag_n   = ctrl_flag_q;
		emit          = 1'b0;

		if (beat_s1.start_of_packet) begin
			// a new header always abandons an unfinished packet
			active_n = 1'b0;
			if (hdr_ok) begin
				id_bytes_n    = hdr_id_bytes[2:0];
				addr_bytes_n  = hdr_addr_bytes[2:0];
				items_left_n  = hdr_items;
				heap_size_n   = '0;
				heap_offset_n = '0;
				payload_len_n = '0;
				vis_start_n   = '0;
				ts_count_n    = '0;
				ts_frac_n     = '0;
				hdr_flag_n    = 1'b0;
				ctrl_flag_n   = 1'b0;
				if (hdr_items == 8'd0) begin
					emit = 1'b1;
				end else begin
					active_n = 1'b1;
				end
			end
		end else if (active_q) begin
			case (fields.kind)
				KIND_HEAP_CNT:    heap_cnt_n    = fields.addr[31:0] - 32'd2;
				KIND_HEAP_SIZE:   heap_size_n   = fields.addr;
				KIND_HEAP_OFFSET: heap_offset_n = fields.addr;
				KIND_PAYLOAD_LEN: payload_len_n = fields.addr;
				KIND_STREAM_CTRL: begin
					ctrl_flag_n = 1'b1;
					if (fields.addr == STREAM_STOP) begin
						done_n = 1'b1;
					end
				end
				KIND_TS_COUNT: begin
					ts_count_n = swap32(fields.addr[31:0]);
					hdr_flag_n = 1'b1;
				end
				KIND_TS_FRACTION: begin
					ts_frac_n  = swap32(fields.addr[31:0]);
					hdr_flag_n = 1'b1;
				end
				KIND_BASELINES: begin
					baselines_n = swap32(fields.addr[31:0]);
					hdr_flag_n  = 1'b1;
				end
				KIND_SCAN_HDR: hdr_flag_n = 1'b1;
				KIND_VIS_OFFSET: begin
					vis_off_n   = fields.addr;
					vis_start_n = fields.addr;
				end
				default: ;
			endcase
			items_left_n = items_left_q - 8'd1;
			if (items_left_n == 8'd0) begin
				active_n = 1'b0;
				emit     = 1'b1;
			end
		end
	end

	// descriptor built from the updated state
	always_comb begin
		result_d.heap_index      = heap_cnt_n;
		result_d.heap_len        = heap_size_n;
		result_d.heap_pos        = heap_offset_n;
		result_d.vis_start       = vis_start_n;
		result_d.vis_length      = (payload_len_n > vis_start_n) ?
			(payload_len_n - vis_start_n) : 56'd0;
		result_d.vis_base_offset = vis_off_n;
		result_d.ts_whole        = ts_count_n;
		result_d.ts_part         = ts_frac_n;
		result_d.baseline_count  = baselines_n;
		result_d.has_header_data = hdr_flag_n;
		result_d.stream_done     = done_n;
		result_d.copy_request    = !ctrl_flag_n && (vis_off_n != 56'd0) &&
			(baselines_n != 32'd0) && !baselines_n[31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			addr_bytes_q  <= '0;
			id_bytes_q    <= '0;
			items_left_q  <= '0;
			heap_cnt_q    <= '0;
			vis_off_q     <= '0;
			baselines_q   <= '0;
			done_q        <= 1'b0;
			heap_size_q   <= '0;
			heap_offset_q <= '0;
			payload_len_q <= '0;
			vis_start_q   <= '0;
			ts_count_q    <= '0;
			ts_frac_q     <= '0;
			hdr_flag_q    <= 1'b0;
			ctrl_flag_q   <= 1'b0;
		end else if (advance) begin
			active_q      <= active_n;
			addr_bytes_q  <= addr_bytes_n;
			id_bytes_q    <= id_bytes_n;
			items_left_q  <= items_left_n;
			heap_cnt_q    <= heap_cnt_n;
			vis_off_q     <= vis_off_n;
			baselines_q   <= baselines_n;
			done_q        <= done_n;
			heap_size_q   <= heap_size_n;
			heap_offset_q <= heap_offset_n;
			payload_len_q <= payload_len_n;
			vis_start_q   <= vis_start_n;
			ts_count_q    <= ts_count_n;
			ts_frac_q     <= ts_frac_n;
			hdr_flag_q    <= hdr_flag_n;
			ctrl_flag_q   <= ctrl_flag_n;
		end
	end

	// result register: loads on emit, empties when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTH
	// an open item list always has a word still to come
	a_active_items: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (items_left_q != 8'd0))
		else $error("item list open with no items left");

	// widths are only latched from a good header
	a_active_widths: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (addr_bytes_q != 3'd0 && id_bytes_q != 3'd0))
		else $error("item list open with zero field width");

	// stream done never clears once set
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> done_q)
		else $error("stream done flag cleared");

	// the last item word of a packet yields a descriptor
	a_last_item_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !beat_s1.start_of_packet && active_q && items_left_q == 8'd1)
		|=> result_valid_q)
		else $error("last item word did not produce a descriptor");
`endif

endmodule
